// ===== hw/rtl/jtgc_pkg.sv =====
// Shared types and codes for the JSON token grammar checker.
package jtgc_pkg;

  // Token kinds as they arrive from the tokenizer.
  localparam logic [3:0] KIND_OBJ_BEGIN = 4'd0;
  localparam logic [3:0] KIND_OBJ_END   = 4'd1;
  localparam logic [3:0] KIND_ARR_BEGIN = 4'd2;
  localparam logic [3:0] KIND_ARR_END   = 4'd3;
  localparam logic [3:0] KIND_STRING    = 4'd4;
  localparam logic [3:0] KIND_NUMBER    = 4'd5;
  localparam logic [3:0] KIND_TRUE      = 4'd6;
  localparam logic [3:0] KIND_FALSE     = 4'd7;
  localparam logic [3:0] KIND_NULL      = 4'd8;
  localparam logic [3:0] KIND_COLON     = 4'd9;
  localparam logic [3:0] KIND_COMMA     = 4'd10;
  localparam logic [3:0] KIND_EOF       = 4'd11;

  // Event codes on the result channel.
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_OBJ_BEGIN = 4'd1;
  localparam logic [3:0] EV_OBJ_END   = 4'd2;
  localparam logic [3:0] EV_ARR_BEGIN = 4'd3;
  localparam logic [3:0] EV_ARR_END   = 4'd4;
  localparam logic [3:0] EV_KEY       = 4'd5;
  localparam logic [3:0] EV_STRING    = 4'd6;
  localparam logic [3:0] EV_NUMBER    = 4'd7;
  localparam logic [3:0] EV_BOOL      = 4'd8;
  localparam logic [3:0] EV_NULL      = 4'd9;

  // Expectation modes of the parser.
  localparam logic [1:0] MODE_VALUE     = 2'd0;
  localparam logic [1:0] MODE_KEY       = 2'd1;
  localparam logic [1:0] MODE_COLON     = 2'd2;
  localparam logic [1:0] MODE_COMMA_END = 2'd3;

  // Operation classes produced by the front end.
  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_CLOSE  = 3'd1;
  localparam logic [2:0] OP_STRING = 3'd2;
  localparam logic [2:0] OP_SCALAR = 3'd3;
  localparam logic [2:0] OP_COLON  = 3'd4;
  localparam logic [2:0] OP_COMMA  = 3'd5;
  localparam logic [2:0] OP_EOF    = 3'd6;
  localparam logic [2:0] OP_BAD    = 3'd7;

  localparam int TEXT_W = 16;

  typedef struct packed {
    logic [2:0] op;        // operation class
    logic       is_obj;    // bracket belongs to an object
    logic       bool_val;  // value of a boolean literal
    logic [3:0] ev;        // event for scalars and brackets on success
    logic       has_text;  // number literal carries its text span
  } tok_t;

  typedef struct packed {
    tok_t              tok;
    logic [TEXT_W-1:0] offset;
    logic [TEXT_W-1:0] length;
  } qent_t;

endpackage

// ===== hw/rtl/json_token_grammar_checker_top.sv =====
// Top level of the JSON token grammar checker.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   token_kind, token_offset, token_length
//  out      output     out_valid/out_stall event_code, bool_value, text_offset,
//                                          text_length, error_seen, document_end,
//                                          accepted
//
// One token per cycle is sustained while out_stall is low; each token passes
// through front decode into a two-entry queue, then the grammar engine writes
// its result register. The stack top and the mark below it are held in
// registers, and a pop refills the lower one from the stack memory, so a pop
// never waits. Reset clears mode, depth, error flag, queue and result valid;
// the stack memory is not cleared. A stalled result holds its register, the
// queue fills behind it, and in_stall rises once both entries are taken.
module json_token_grammar_checker_top import jtgc_pkg::*; #(
  parameter int MAX_DEPTH    = 16,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_token_kind,
  input  logic [TEXT_W-1:0] in_token_offset,
  input  logic [TEXT_W-1:0] in_token_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_event_code,
  output logic              out_bool_value,
  output logic [TEXT_W-1:0] out_text_offset,
  output logic [TEXT_W-1:0] out_text_length,
  output logic              out_error_seen,
  output logic              out_document_end,
  output logic              out_accepted
);

  qent_t q_entry;
  qent_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;

  jtgc_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_token_kind  (in_token_kind),
    .in_token_offset(in_token_offset),
    .in_token_length(in_token_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  jtgc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  jtgc_back #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_bool_value  (out_bool_value),
    .out_text_offset (out_text_offset),
    .out_text_length (out_text_length),
    .out_error_seen  (out_error_seen),
    .out_document_end(out_document_end),
    .out_accepted    (out_accepted)
  );

  // An erroring or post-error token never reports an event.
  a_err_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_seen |-> out_event_code == EV_NONE)
    else $error("event reported with error flag set");

  // End of input carries no event, and acceptance only comes with it.
  a_eof_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_document_end |-> out_event_code == EV_NONE)
    else $error("event reported on end of input");

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_document_end && !out_error_seen)
    else $error("accepted without clean end of input");

  // Text spans appear only on key, string and number events.
  a_text_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_event_code == EV_KEY || out_event_code == EV_STRING ||
                   out_event_code == EV_NUMBER)
    |-> out_text_offset == '0 && out_text_length == '0)
    else $error("text span on an event without text");

  // A full queue with no result leaving means the input must be stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |-> in_stall)
    else $error("input not stalled with a full queue");

endmodule

// ===== hw/rtl/jtgc_front.sv =====
// Front end: accepts tokens and classifies them into queue entries.
module jtgc_front import jtgc_pkg::*; #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_token_kind,
  input  logic [TEXT_W-1:0] in_token_offset,
  input  logic [TEXT_W-1:0] in_token_length,
  input  logic              q_full,
  output logic              q_push,
  output qent_t             q_entry
);

  localparam logic [TEXT_W-1:0] TEXT_MASK = (OFFSET_WIDTH >= TEXT_W) ? {TEXT_W{1'b1}} :
      TEXT_W'((64'd1 << OFFSET_WIDTH) - 64'd1);

  tok_t tok;

  always_comb begin
    tok = '0;
    unique case (in_token_kind)
      KIND_OBJ_BEGIN: begin
        tok.op = OP_OPEN;
        tok.is_obj = 1'b1;
        tok.ev = EV_OBJ_BEGIN;
      end
      KIND_ARR_BEGIN: begin
        tok.op = OP_OPEN;
        tok.ev = EV_ARR_BEGIN;
      end
      KIND_OBJ_END: begin
        tok.op = OP_CLOSE;
        tok.is_obj = 1'b1;
        tok.ev = EV_OBJ_END;
      end
      KIND_ARR_END: begin
        tok.op = OP_CLOSE;
        tok.ev = EV_ARR_END;
      end
      KIND_STRING: tok.op = OP_STRING;
      KIND_NUMBER: begin
        tok.op = OP_SCALAR;
        tok.ev = EV_NUMBER;
        tok.has_text = 1'b1;
      end
      KIND_TRUE: begin
        tok.op = OP_SCALAR;
        tok.ev = EV_BOOL;
        tok.bool_val = 1'b1;
      end
      KIND_FALSE: begin
        tok.op = OP_SCALAR;
        tok.ev = EV_BOOL;
      end
      KIND_NULL: begin
        tok.op = OP_SCALAR;
        tok.ev = EV_NULL;
      end
      KIND_COLON: tok.op = OP_COLON;
      KIND_COMMA: tok.op = OP_COMMA;
      KIND_EOF:   tok.op = OP_EOF;
      default:    tok.op = OP_BAD;
    endcase
  end

  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full;
  assign q_entry.tok    = tok;
  assign q_entry.offset = in_token_offset & TEXT_MASK;
  assign q_entry.length = in_token_length & TEXT_MASK;

endmodule

// ===== hw/rtl/jtgc_queue.sv =====
// Two-entry queue between the front end and the grammar engine.
module jtgc_queue import jtgc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output qent_t head,
  output logic  empty,
  output logic  full
);

  qent_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

endmodule

// ===== hw/rtl/jtgc_back.sv =====
// Grammar engine: expectation mode, nesting stack, error flag and result register.
module jtgc_back import jtgc_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  qent_t             q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_event_code,
  output logic              out_bool_value,
  output logic [TEXT_W-1:0] out_text_offset,
  output logic [TEXT_W-1:0] out_text_length,
  output logic              out_error_seen,
  output logic              out_document_end,
  output logic              out_accepted
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_DEPTH);

  // The top mark and the one below it live in registers; the rest sits in
  // the stack memory, from which a pop refills the register below the top.
  logic          stack_mem [MAX_DEPTH];
  logic [1:0]    mode_r, mode_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          top_r, top_nxt;
  logic          below_r, below_nxt;
  logic          err_r, err_nxt;
  logic          do_push, do_pop;
  logic [DW-1:0] rd_depth;

  logic              out_valid_r;
  logic [3:0]        ev_r, ev_nxt;
  logic              bval_r, bval_nxt;
  logic [TEXT_W-1:0] off_r, off_nxt;
  logic [TEXT_W-1:0] len_r, len_nxt;
  logic              errs_r, errs_nxt;
  logic              dend_r, dend_nxt;
  logic              acc_r, acc_nxt;

  logic load;
  logic fail;
  logic text;

  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    below_nxt = below_r;
    err_nxt   = err_r;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    fail      = 1'b0;
    text      = 1'b0;
    ev_nxt    = EV_NONE;
    bval_nxt  = 1'b0;
    dend_nxt  = 1'b0;
    acc_nxt   = 1'b0;

    if (q_head.tok.op == OP_EOF) begin
      dend_nxt  = 1'b1;
      acc_nxt   = !err_r;
      mode_nxt  = MODE_VALUE;
      depth_nxt = '0;
      err_nxt   = 1'b0;
    end else if (!err_r) begin
      unique case (q_head.tok.op)
        OP_OPEN: begin
          if (mode_r != MODE_VALUE || depth_r == DEPTH_FULL) begin
            fail = 1'b1;
          end else begin
            do_push   = 1'b1;
            depth_nxt = depth_r + DW'(1);
            top_nxt   = q_head.tok.is_obj;
            below_nxt = top_r;
            mode_nxt  = q_head.tok.is_obj ? MODE_KEY : MODE_VALUE;
            ev_nxt    = q_head.tok.ev;
          end
        end
        OP_CLOSE: begin
          if (depth_r == '0 || top_r != q_head.tok.is_obj) begin
            fail = 1'b1;
          end else begin
            do_pop    = 1'b1;
            depth_nxt = depth_r - DW'(1);
            top_nxt   = below_r;
            mode_nxt  = MODE_COMMA_END;
            ev_nxt    = q_head.tok.ev;
          end
        end
        OP_STRING: begin
          if (mode_r == MODE_KEY) begin
            ev_nxt   = EV_KEY;
            text     = 1'b1;
            mode_nxt = MODE_COLON;
          end else if (mode_r == MODE_VALUE) begin
            ev_nxt   = EV_STRING;
            text     = 1'b1;
            mode_nxt = MODE_COMMA_END;
          end else begin
            fail = 1'b1;
          end
        end
        OP_SCALAR: begin
          if (mode_r != MODE_VALUE) begin
            fail = 1'b1;
          end else begin
            mode_nxt = MODE_COMMA_END;
            ev_nxt   = q_head.tok.ev;
            bval_nxt = q_head.tok.bool_val;
            text     = q_head.tok.has_text;
          end
        end
        OP_COLON: begin
          if (mode_r != MODE_COLON) begin
            fail = 1'b1;
          end else begin
            mode_nxt = MODE_VALUE;
          end
        end
        OP_COMMA: begin
          if (mode_r != MODE_COMMA_END || depth_r == '0) begin
            fail = 1'b1;
          end else begin
            mode_nxt = top_r ? MODE_KEY : MODE_VALUE;
          end
        end
        default: fail = 1'b1;
      endcase

      // A failing token sets the error flag and leaves all other parser state as it was.
      if (fail) begin
        mode_nxt  = mode_r;
        depth_nxt = depth_r;
        top_nxt   = top_r;
        below_nxt = below_r;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        err_nxt   = 1'b1;
        ev_nxt    = EV_NONE;
        bval_nxt  = 1'b0;
        text      = 1'b0;
      end
    end

    off_nxt  = text ? q_head.offset : '0;
    len_nxt  = text ? q_head.length : '0;
    errs_nxt = err_r || fail;
  end

  assign rd_depth = depth_r - DW'(3);

  always_ff @(posedge clk) begin
    if (load && do_push) begin
      stack_mem[depth_r[AW-1:0]] <= q_head.tok.is_obj;
    end
    if (load && do_pop && ({1'b0, depth_r} >= (DW + 1)'(3))) begin
      below_r <= stack_mem[rd_depth[AW-1:0]];
    end else if (load) begin
      below_r <= below_nxt;
    end
    if (load) begin
      top_r  <= top_nxt;
      ev_r   <= ev_nxt;
      bval_r <= bval_nxt;
      off_r  <= off_nxt;
      len_r  <= len_nxt;
      errs_r <= errs_nxt;
      dend_r <= dend_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_VALUE;
      depth_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        err_r   <= err_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = ev_r;
  assign out_bool_value   = bval_r;
  assign out_text_offset  = off_r;
  assign out_text_length  = len_r;
  assign out_error_seen   = errs_r;
  assign out_document_end = dend_r;
  assign out_accepted     = acc_r;

endmodule

// ===== tb/json_token_grammar_checker_top_tb.sv =====
// Self-checking testbench for the JSON token grammar checker against a grammar predictor.
module json_token_grammar_checker_top_tb import jtgc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NEST       = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_TOKENS   = 375;

  // Kinds the package leaves unnamed.
  localparam logic [3:0] KIND_TOK_ERROR  = 4'd12;
  localparam logic [3:0] KIND_INVALID_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] off;
    logic [15:0] len;
  } token_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic        bval;
    logic [15:0] toff;
    logic [15:0] tlen;
    logic        err;
    logic        doc_end;
    logic        acc;
  } json_event_t;

  typedef struct packed {
    token_t      tok;
    logic        typed;
    json_event_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [3:0]        in_token_kind = '0;
  logic [TEXT_W-1:0] in_token_offset = '0;
  logic [TEXT_W-1:0] in_token_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_event_code;
  logic              out_bool_value;
  logic [TEXT_W-1:0] out_text_offset;
  logic [TEXT_W-1:0] out_text_length;
  logic              out_error_seen;
  logic              out_document_end;
  logic              out_accepted;

  // Travels with each token: the directed rows whose result is typed in.
  logic        row_typed = 1'b0;
  json_event_t row_result = '0;

  // Grammar predictor state.
  logic [1:0] gram_mode = MODE_VALUE;
  int         gram_depth = 0;
  logic       gram_stack [MAX_NEST];
  logic       gram_err = 1'b0;

  json_event_t pending_events[$];
  json_event_t predicted, got, want;
  token_t      doc_tokens[$];
  dir_row_t    dir_rows[$];

  logic [3:0] scalar_kinds [5] = '{KIND_STRING, KIND_NUMBER, KIND_TRUE, KIND_FALSE, KIND_NULL};
  int send_idle_tab [4] = '{0, 55, 0, 30};
  int stall_tab     [4] = '{0, 0, 55, 30};

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  tokens_sent = 0;
  int  docs_sent = 0;
  int  docs_ok = 0;
  int  docs_rejected = 0;
  int  deepest = 0;
  int  phase_count;

  json_token_grammar_checker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_token_kind    (in_token_kind),
    .in_token_offset  (in_token_offset),
    .in_token_length  (in_token_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_bool_value   (out_bool_value),
    .out_text_offset  (out_text_offset),
    .out_text_length  (out_text_length),
    .out_error_seen   (out_error_seen),
    .out_document_end (out_document_end),
    .out_accepted     (out_accepted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic json_event_t predict_token(input logic [3:0] kind,
                                                input logic [15:0] off,
                                                input logic [15:0] len);
    json_event_t r;
    logic        fail;
    logic        text;
    logic        is_obj;
    r = '0;
    fail = 1'b0;
    text = 1'b0;
    is_obj = (kind == KIND_OBJ_BEGIN) || (kind == KIND_OBJ_END);
    if (kind == KIND_EOF) begin
      r.doc_end = 1'b1;
      r.acc = !gram_err;
    end else if (!gram_err) begin
      case (kind)
        KIND_OBJ_BEGIN, KIND_ARR_BEGIN: begin
          if (gram_mode != MODE_VALUE || gram_depth >= MAX_NEST) begin
            fail = 1'b1;
          end else begin
            gram_stack[gram_depth] = is_obj;
            gram_depth++;
            if (gram_depth > deepest) deepest = gram_depth;
            gram_mode = is_obj ? MODE_KEY : MODE_VALUE;
            r.ev = is_obj ? EV_OBJ_BEGIN : EV_ARR_BEGIN;
          end
        end
        KIND_OBJ_END, KIND_ARR_END: begin
          // Closers look only at the stack top, whatever the mode.
          if (gram_depth == 0) begin
            fail = 1'b1;
          end else if (gram_stack[gram_depth-1] != is_obj) begin
            fail = 1'b1;
          end else begin
            gram_depth--;
            gram_mode = MODE_COMMA_END;
            r.ev = is_obj ? EV_OBJ_END : EV_ARR_END;
          end
        end
        KIND_STRING: begin
          if (gram_mode == MODE_KEY) begin
            r.ev = EV_KEY;
            text = 1'b1;
            gram_mode = MODE_COLON;
          end else if (gram_mode == MODE_VALUE) begin
            r.ev = EV_STRING;
            text = 1'b1;
            gram_mode = MODE_COMMA_END;
          end else begin
            fail = 1'b1;
          end
        end
        KIND_NUMBER, KIND_TRUE, KIND_FALSE, KIND_NULL: begin
          if (gram_mode != MODE_VALUE) begin
            fail = 1'b1;
          end else begin
            gram_mode = MODE_COMMA_END;
            if (kind == KIND_NUMBER) begin
              r.ev = EV_NUMBER;
              text = 1'b1;
            end else if (kind == KIND_NULL) begin
              r.ev = EV_NULL;
            end else begin
              r.ev = EV_BOOL;
              r.bval = (kind == KIND_TRUE);
            end
          end
        end
        KIND_COLON: begin
          if (gram_mode != MODE_COLON) fail = 1'b1;
          else gram_mode = MODE_VALUE;
        end
        KIND_COMMA: begin
          if (gram_mode != MODE_COMMA_END || gram_depth == 0) fail = 1'b1;
          else gram_mode = gram_stack[gram_depth-1] ? MODE_KEY : MODE_VALUE;
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail) begin
        gram_err = 1'b1;
        r.ev = EV_NONE;
        r.bval = 1'b0;
        text = 1'b0;
      end
    end
    r.err = gram_err;
    if (text) begin
      r.toff = off;
      r.tlen = len;
    end
    if (kind == KIND_EOF) begin
      gram_mode = MODE_VALUE;
      gram_depth = 0;
      gram_err = 1'b0;
    end
    return r;
  endfunction

  function automatic token_t make_token(input logic [3:0] kind);
    token_t t;
    t.kind = kind;
    t.off = 16'($urandom);
    t.len = 16'($urandom);
    return t;
  endfunction

  task automatic add_row(input logic [3:0] kind, input logic [15:0] off,
                         input logic [15:0] len);
    dir_row_t r;
    r.tok.kind = kind;
    r.tok.off = off;
    r.tok.len = len;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_typed_row(input logic [3:0] kind, input logic [15:0] off,
                               input logic [15:0] len, input logic [3:0] ev,
                               input logic bval, input logic [15:0] toff,
                               input logic [15:0] tlen, input logic err,
                               input logic dend, input logic acc);
    dir_row_t r;
    r.tok.kind = kind;
    r.tok.off = off;
    r.tok.len = len;
    r.typed = 1'b1;
    r.want = '{ev, bval, toff, tlen, err, dend, acc};
    dir_rows.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_token(input token_t t, input logic typed, input json_event_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_token_kind   <= t.kind;
    in_token_offset <= t.off;
    in_token_length <= t.len;
    row_typed       <= typed;
    row_result      <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    tokens_sent++;
  endtask

  task automatic gen_value(input int lvl, input int target, input bit chain);
    int n;
    bit is_obj;
    if (lvl < target && (chain || $urandom_range(0, 2) != 0)) begin
      is_obj = 1'($urandom_range(0, 1));
      n = chain ? 1 : $urandom_range(0, 3);
      doc_tokens.push_back(make_token(is_obj ? KIND_OBJ_BEGIN : KIND_ARR_BEGIN));
      for (int i = 0; i < n; i++) begin
        if (i > 0) doc_tokens.push_back(make_token(KIND_COMMA));
        if (is_obj) begin
          doc_tokens.push_back(make_token(KIND_STRING));
          doc_tokens.push_back(make_token(KIND_COLON));
        end
        gen_value(lvl + 1, target, chain);
      end
      doc_tokens.push_back(make_token(is_obj ? KIND_OBJ_END : KIND_ARR_END));
    end else begin
      doc_tokens.push_back(make_token(scalar_kinds[$urandom_range(0, 4)]));
    end
  endtask

  // Mostly well-formed documents; some get one token broken, dropped or added,
  // and some are plain noise. Deep chains probe the depth limit.
  task automatic build_document();
    int style;
    int idx;
    doc_tokens.delete();
    style = $urandom_range(0, 9);
    if (style == 9) begin
      repeat ($urandom_range(1, 12)) doc_tokens.push_back(make_token(4'($urandom_range(0, 15))));
    end else if ($urandom_range(0, 15) == 0) begin
      gen_value(0, $urandom_range(MAX_NEST - 1, MAX_NEST + 1), 1'b1);
    end else begin
      gen_value(0, $urandom_range(0, 3), 1'b0);
    end
    idx = $urandom_range(0, doc_tokens.size() - 1);
    case (style)
      6: doc_tokens[idx].kind = 4'($urandom_range(0, 15));
      7: doc_tokens.delete(idx);
      8: doc_tokens.insert(idx, make_token(4'($urandom_range(0, 15))));
      default: ;
    endcase
    doc_tokens.push_back(make_token(KIND_EOF));
  endtask

  task automatic report(input string field, input logic [15:0] exp_val,
                        input logic [15:0] act_val);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  // Output side: random stall, or a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Transfer monitors, result check and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_event_code, out_bool_value, out_text_offset, out_text_length,
                out_error_seen, out_document_end, out_accepted};
        if (pending_events.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (got.ev !== want.ev) report("event_code", 16'(want.ev), 16'(got.ev));
          if (got.bval !== want.bval) report("bool_value", 16'(want.bval), 16'(got.bval));
          if (got.toff !== want.toff) report("text_offset", want.toff, got.toff);
          if (got.tlen !== want.tlen) report("text_length", want.tlen, got.tlen);
          if (got.err !== want.err) report("error_seen", 16'(want.err), 16'(got.err));
          if (got.doc_end !== want.doc_end) begin
            report("document_end", 16'(want.doc_end), 16'(got.doc_end));
          end
          if (got.acc !== want.acc) report("accepted", 16'(want.acc), 16'(got.acc));
        end
        if (got.doc_end === 1'b1) begin
          if (got.acc === 1'b1) docs_ok++;
          else docs_rejected++;
        end
      end
      if (in_valid && !in_stall) begin
        predicted = predict_token(in_token_kind, in_token_offset, in_token_length);
        pending_events.push_back(row_typed ? row_result : predicted);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_events.size());
        $display("** json_token_grammar_checker_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // Valid document, reset behavior and the error paths.
    add_typed_row(KIND_NUMBER, 16'hFFFF, 16'hFFFF, EV_NUMBER, 1'b0, 16'hFFFF, 16'hFFFF,
                  1'b0, 1'b0, 1'b0);
    add_typed_row(KIND_EOF, 16'hFFFF, 16'hFFFF, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1);
    add_row(KIND_OBJ_BEGIN, 16'h0000, 16'h0000);
    add_row(KIND_STRING, 16'h0000, 16'h0000);
    add_row(KIND_COLON, 16'h0001, 16'h0001);
    add_row(KIND_TRUE, 16'h0002, 16'h0004);
    add_row(KIND_COMMA, 16'h0006, 16'h0001);
    add_row(KIND_STRING, 16'h1234, 16'h00A5);
    add_row(KIND_COLON, 16'h5A5A, 16'hA5A5);
    add_row(KIND_ARR_BEGIN, 16'h0100, 16'h0001);
    add_row(KIND_FALSE, 16'h0101, 16'h0005);
    add_row(KIND_COMMA, 16'h0106, 16'h0001);
    add_row(KIND_NULL, 16'h0107, 16'h0004);
    add_row(KIND_COMMA, 16'h010B, 16'h0001);
    add_row(KIND_NUMBER, 16'h0000, 16'hFFFF);
    add_row(KIND_ARR_END, 16'h0200, 16'h0001);
    add_row(KIND_OBJ_END, 16'h0201, 16'h0001);
    add_typed_row(KIND_EOF, 16'h0202, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1);
    // A comma outside any container is an error, and the error is sticky.
    add_typed_row(KIND_COMMA, 16'h0000, 16'h0001, EV_NONE, 1'b0, 16'h0, 16'h0,
                  1'b1, 1'b0, 1'b0);
    add_typed_row(KIND_STRING, 16'h0001, 16'h0003, EV_NONE, 1'b0, 16'h0, 16'h0,
                  1'b1, 1'b0, 1'b0);
    add_typed_row(KIND_EOF, 16'h0004, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b1, 1'b1, 1'b0);
    // Closing an array with a brace.
    add_row(KIND_ARR_BEGIN, 16'h0000, 16'h0001);
    add_typed_row(KIND_OBJ_END, 16'h0001, 16'h0001, EV_NONE, 1'b0, 16'h0, 16'h0,
                  1'b1, 1'b0, 1'b0);
    add_typed_row(KIND_EOF, 16'h0002, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b1, 1'b1, 1'b0);
    add_typed_row(KIND_TOK_ERROR, 16'h0000, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0,
                  1'b1, 1'b0, 1'b0);
    add_typed_row(KIND_EOF, 16'h0000, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b1, 1'b1, 1'b0);
    add_typed_row(KIND_INVALID_HI, 16'hFFFF, 16'hFFFF, EV_NONE, 1'b0, 16'h0, 16'h0,
                  1'b1, 1'b0, 1'b0);
    add_typed_row(KIND_EOF, 16'h0000, 16'h0000, EV_NONE, 1'b0, 16'h0, 16'h0, 1'b1, 1'b1, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].want);
    docs_sent += 6;
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tab[ph];
      stall_pct = stall_tab[ph];
      // The first phase opens with the output held off while tokens keep coming.
      if (ph == 0) hold_req = 1'b1;
      phase_count = 0;
      while (phase_count < PHASE_TOKENS) begin
        build_document();
        foreach (doc_tokens[i]) offer_token(doc_tokens[i], 1'b0, '0);
        phase_count += doc_tokens.size();
        docs_sent++;
      end
      // Let every result come back before the next mix.
      in_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d tokens in %0d documents: %0d accepted, %0d rejected,",
             tokens_sent, docs_sent, docs_ok, docs_rejected);
    $display("depth reached %0d; idle/stall mixes 0/0, 55/0, 0/55, 30/30, %0d-cycle hold-off.",
             deepest, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** json_token_grammar_checker_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** json_token_grammar_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/jtgc_pkg.sv
hw/rtl/jtgc_front.sv
hw/rtl/jtgc_queue.sv
hw/rtl/jtgc_back.sv
hw/rtl/json_token_grammar_checker_top.sv
tb/json_token_grammar_checker_top_tb.sv
